// File: hw/rtl/assert_macros.svh
// assertion helpers used by the checker file
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a rising clock, off while reset is low
`define PTS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// same with a caller message
`define PTS_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error(msg);

`endif

// File: hw/rtl/pts_pkg.sv
// shared constants and controller/datapath interface types for the tick scheduler
// no dependencies
package pts_pkg;

  localparam int unsigned NumTasksDef = 8;
  localparam int unsigned PrioBitsDef = 8;

  localparam int unsigned IdxW   = 3;
  localparam int unsigned ValW   = 8;
  localparam int unsigned TaskW  = 3;
  localparam int unsigned SliceW = 8;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec_load;
    logic exec_dec;
    logic sweep_init;
    logic scan_rd;
    logic pick_slice;
    logic reload_rd;
    logic pick_any;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_load;
    logic cnt_zero;
    logic addr_last;
    logic slice_found;
  } sts_t;

endpackage

// File: hw/rtl/pts_ctrl.sv
// sequencer for the tick scheduler: accept, execute, scan, reload, deliver
// depends on pts_pkg
module pts_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  pts_pkg::sts_t sts_i,
  output pts_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle, StExec, StScan, StDrain, StDecide, StReload, StRlDrain, StDone
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StExec;
        end
      end
      StExec: begin
        if (sts_i.req_load) begin
          cmd_o.exec_load = 1'b1;
          state_d         = StDone;
        end else if (!sts_i.cnt_zero) begin
          cmd_o.exec_dec = 1'b1;
          state_d        = StDone;
        end else begin
          cmd_o.sweep_init = 1'b1;
          state_d          = StScan;
        end
      end
      StScan: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.addr_last) state_d = StDrain;
      end
      StDrain: state_d = StDecide;
      StDecide: begin
        if (sts_i.slice_found) begin
          cmd_o.pick_slice = 1'b1;
          state_d          = StDone;
        end else begin
          cmd_o.sweep_init = 1'b1;
          state_d          = StReload;
        end
      end
      StReload: begin
        cmd_o.reload_rd = 1'b1;
        if (sts_i.addr_last) state_d = StRlDrain;
      end
      StRlDrain: begin
        cmd_o.pick_any = 1'b1;
        state_d        = StDone;
      end
      StDone: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/pts_dp.sv
// datapath of the tick scheduler: priority and slice memories, scan, result register
// depends on pts_pkg
module pts_dp #(
  parameter int unsigned NUM_TASKS = pts_pkg::NumTasksDef,
  parameter int unsigned PRIO_BITS = pts_pkg::PrioBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pts_pkg::cmd_t               cmd_i,
  output pts_pkg::sts_t               sts_o,
  input  logic                        req_type_i,
  input  logic [pts_pkg::IdxW-1:0]    task_index_i,
  input  logic [pts_pkg::ValW-1:0]    priority_value_i,
  output logic [pts_pkg::TaskW-1:0]   running_task_o,
  output logic                        switched_o,
  output logic                        reloaded_o,
  output logic [pts_pkg::SliceW-1:0]  slice_left_o
);

  localparam int unsigned TW = $clog2(NUM_TASKS);
  localparam int unsigned PW = PRIO_BITS;

  logic [PW-1:0] prio_mem [NUM_TASKS];
  logic [PW-1:0] cnt_mem  [NUM_TASKS];
  logic [NUM_TASKS-1:0] prio_vld_q, cnt_vld_q;

  logic                    req_type_q;
  logic [pts_pkg::IdxW-1:0] req_idx_q;
  logic [PW-1:0]           req_val_q;

  logic [TW-1:0] cur_task_q;
  logic [PW-1:0] cur_cnt_q;
  logic          sw_q, rl_q;

  logic [TW-1:0] addr_q;
  logic          cmp_v_q, rl_v_q;
  logic [TW-1:0] rd_idx_q;
  logic [PW-1:0] prio_rd_q, cnt_rd_q;
  logic          prio_rv_q, cnt_rv_q;
  logic [PW-1:0] prio_val, cnt_val;

  logic          any_found_q, sl_found_q;
  logic [TW-1:0] any_idx_q, sl_idx_q;
  logic [PW-1:0] any_prio_q, sl_prio_q, sl_cnt_q;
  logic          upd_any, upd_sl;

  logic          load_ok;
  logic [TW-1:0] load_addr;

  logic [pts_pkg::TaskW-1:0]  out_task_q;
  logic                       out_sw_q, out_rl_q;
  logic [pts_pkg::SliceW-1:0] out_slice_q;

  // invalid entries read as the reset value zero
  assign prio_val = prio_rv_q ? prio_rd_q : '0;
  assign cnt_val  = cnt_rv_q  ? cnt_rd_q  : '0;

  assign upd_any = cmp_v_q && (!any_found_q || (prio_val < any_prio_q));
  assign upd_sl  = cmp_v_q && (cnt_val != '0) && (!sl_found_q || (prio_val < sl_prio_q));

  assign load_ok   = (req_idx_q != '0) && (32'(req_idx_q) < NUM_TASKS);
  assign load_addr = TW'(req_idx_q);

  assign sts_o.req_load    = req_type_q;
  assign sts_o.cnt_zero    = (cur_cnt_q == '0);
  assign sts_o.addr_last   = (addr_q == TW'(NUM_TASKS - 1));
  assign sts_o.slice_found = sl_found_q;

  // memories: one write port each, registered read at the sweep address
  always_ff @(posedge clk_i) begin
    prio_rd_q <= prio_mem[addr_q];
    cnt_rd_q  <= cnt_mem[addr_q];
    if (cmd_i.exec_load && load_ok) begin
      prio_mem[load_addr] <= req_val_q;
    end
    if (cmd_i.exec_dec) begin
      cnt_mem[cur_task_q] <= cur_cnt_q - 1'b1;
    end else if (rl_v_q) begin
      cnt_mem[rd_idx_q] <= prio_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_vld_q  <= '0;
      cnt_vld_q   <= '0;
      prio_rv_q   <= 1'b0;
      cnt_rv_q    <= 1'b0;
      cmp_v_q     <= 1'b0;
      rl_v_q      <= 1'b0;
      cur_task_q  <= '0;
      cur_cnt_q   <= '0;
      sw_q        <= 1'b0;
      rl_q        <= 1'b0;
      req_type_q  <= 1'b0;
      any_found_q <= 1'b0;
      sl_found_q  <= 1'b0;
      addr_q      <= '0;
    end else begin
      prio_rv_q <= prio_vld_q[addr_q];
      cnt_rv_q  <= cnt_vld_q[addr_q];
      cmp_v_q   <= cmd_i.scan_rd;
      rl_v_q    <= cmd_i.reload_rd;
      if (cmd_i.exec_load && load_ok) prio_vld_q[load_addr] <= 1'b1;
      if (cmd_i.exec_dec) begin
        cnt_vld_q[cur_task_q] <= 1'b1;
        cur_cnt_q             <= cur_cnt_q - 1'b1;
      end else if (rl_v_q) begin
        cnt_vld_q[rd_idx_q] <= 1'b1;
      end
      if (cmd_i.capture) begin
        req_type_q <= req_type_i;
        sw_q       <= 1'b0;
        rl_q       <= 1'b0;
      end
      if (cmd_i.sweep_init) begin
        addr_q      <= TW'(1);
        any_found_q <= 1'b0;
        sl_found_q  <= 1'b0;
      end else if (cmd_i.scan_rd || cmd_i.reload_rd) begin
        addr_q <= addr_q + 1'b1;
      end
      if (upd_any) any_found_q <= 1'b1;
      if (upd_sl)  sl_found_q  <= 1'b1;
      if (cmd_i.pick_slice) begin
        sw_q       <= (sl_idx_q != cur_task_q);
        cur_task_q <= sl_idx_q;
        cur_cnt_q  <= sl_cnt_q;
      end else if (cmd_i.pick_any) begin
        sw_q       <= (any_idx_q != cur_task_q);
        rl_q       <= 1'b1;
        cur_task_q <= any_idx_q;
        cur_cnt_q  <= any_prio_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= addr_q;
    if (cmd_i.capture) begin
      req_idx_q <= task_index_i;
      req_val_q <= PW'(priority_value_i);
    end
    if (upd_any) begin
      any_idx_q  <= rd_idx_q;
      any_prio_q <= prio_val;
    end
    if (upd_sl) begin
      sl_idx_q  <= rd_idx_q;
      sl_prio_q <= prio_val;
      sl_cnt_q  <= cnt_val;
    end
    if (cmd_i.out_load) begin
      out_task_q  <= pts_pkg::TaskW'(cur_task_q);
      out_sw_q    <= sw_q;
      out_rl_q    <= rl_q;
      out_slice_q <= pts_pkg::SliceW'(cur_cnt_q);
    end
  end

  assign running_task_o = out_task_q;
  assign switched_o     = out_sw_q;
  assign reloaded_o     = out_rl_q;
  assign slice_left_o   = out_slice_q;

endmodule

// File: hw/rtl/priority_tick_scheduler.sv
// top level of the priority time-slice scheduler
// depends on pts_pkg, pts_ctrl and pts_dp
//
//  channel   dir  handshake                 payload
//  s_*       in   s_tvalid / s_tready       s_tuser = req_type, s_tdata = index, priority
//  m_*       out  m_tvalid / m_tready       m_tdata = task, switched, reloaded, slice left
//
// one beat in, one beat out, one item in flight at a time
// load or decrement: executed in StExec, result registered from StDone once the output is free
// tick that picks: StScan reads one task table entry per cycle, then StDrain and StDecide
// pick with reload: when no slice is left, a second pass copies priorities into the counters
// a stalled result stays in the output register while the next item is taken
// reset clears state, priorities and counters through per-entry valid bits
module priority_tick_scheduler #(
  parameter int unsigned NUM_TASKS = pts_pkg::NumTasksDef,
  parameter int unsigned PRIO_BITS = pts_pkg::PrioBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [pts_pkg::InDataW-1:0]    s_tdata,   // task_index [2:0], priority_value [10:3]
  input  logic                           s_tuser,   // req_type [0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [pts_pkg::OutDataW-1:0]   m_tdata    // running_task [2:0], switched [3],
                                                    // reloaded [4], slice_left [12:5]
);

  pts_pkg::cmd_t cmd;
  pts_pkg::sts_t sts;

  logic [pts_pkg::TaskW-1:0]  running_task;
  logic                       switched;
  logic                       reloaded;
  logic [pts_pkg::SliceW-1:0] slice_left;

  // sequencer
  pts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid),
    .in_ready_o  (s_tready),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // task tables, scan and result register
  pts_dp #(
    .NUM_TASKS (NUM_TASKS),
    .PRIO_BITS (PRIO_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_type_i       (s_tuser),
    .task_index_i     (s_tdata[2:0]),
    .priority_value_i (s_tdata[10:3]),
    .running_task_o   (running_task),
    .switched_o       (switched),
    .reloaded_o       (reloaded),
    .slice_left_o     (slice_left)
  );

  // pack result beat, upper three bits [15:13] of padding are zero
  assign m_tdata = {3'b000, slice_left, reloaded, switched, running_task};

endmodule

// File: hw/rtl/pts_checker.sv
// port-level checks for the tick scheduler, bound to the top level
// depends on assert_macros.svh and pts_pkg
`include "assert_macros.svh"

module pts_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [pts_pkg::OutDataW-1:0] m_tdata
);

  // a stalled result beat holds
  `PTS_ASSERT(a_out_hold, clk_i, rst_ni,
              m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // one item at a time: the input closes right after a beat is taken
  `PTS_ASSERT(a_one_inflight, clk_i, rst_ni, s_tvalid && s_tready |=> !s_tready)

  // a new result only appears while the input side is closed
  `PTS_ASSERT_MSG(a_out_from_busy, clk_i, rst_ni,
                  $rose(m_tvalid) |-> !$past(s_tready), "result without item")

  // the idle task is never picked, so it never comes with a switch or reload
  `PTS_ASSERT_MSG(a_idle_no_pick, clk_i, rst_ni,
                  m_tvalid && (m_tdata[2:0] == 3'd0) |-> m_tdata[4:3] == 2'b00,
                  "idle task picked")

endmodule

bind priority_tick_scheduler pts_checker u_pts_checker (.*);
